// ===== design/texture_nearest_sample_core_defines.svh =====
// assertion macros for the nearest-neighbor texture sampler
`ifndef TEXTURE_NEAREST_SAMPLE_CORE_DEFINES_SVH
`define TEXTURE_NEAREST_SAMPLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TNS_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tns check failed");
`define TNS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tns check failed");
`else
`define TNS_ASSERT(name, clk, rstn, prop)
`define TNS_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

// ===== design/tns_pkg.sv =====
// shared types, constants and helpers of the texture sampler
package tns_pkg;

  localparam int MaxFacesDef  = 1024;
  localparam int TexWordsDef  = 65536;

  localparam int FuncW        = 2;
  localparam int FaceW        = 10;
  localparam int CornerSelW   = 2;
  localparam int CoordW       = 17;
  localparam int TexAddrInW   = 16;
  localparam int ColorW       = 8;
  localparam int WeightW      = 16;
  localparam int CornerW      = 2 * CoordW;
  localparam int TexelW       = 3 * ColorW;
  localparam int SizeW        = 11;
  localparam int PixW         = 11;
  localparam int PixOutW      = 10;
  localparam int AddrW        = 2 * SizeW;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 11;
  localparam int InDataW      = 120;
  localparam int OutDataW     = 48;
  localparam int LaneLat      = 5;
  localparam int OutFifoDepth = 16;

  typedef enum logic [FuncW-1:0] {
    FUNC_WR_CORNER = 2'd0,
    FUNC_WR_TEXEL  = 2'd1,
    FUNC_SAMPLE    = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIFFUSE_RED   = 3'd0,
    CFG_DIFFUSE_GREEN = 3'd1,
    CFG_DIFFUSE_BLUE  = 3'd2,
    CFG_IMAGE_WIDTH   = 3'd3,
    CFG_IMAGE_HEIGHT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic               err;
    logic [PixOutW-1:0] pixel_y;
    logic [PixOutW-1:0] pixel_x;
    rgb_t               color;
  } result_t;

  // exact floor(v / 255) for v below 65280
  function automatic logic [ColorW-1:0] div255(input logic [2*ColorW-1:0] v);
    logic [2*ColorW:0] tmp;
    tmp = {1'b0, v} + {9'd0, v[2*ColorW-1:ColorW]} + 17'd1;
    return tmp[2*ColorW-1:ColorW];
  endfunction

endpackage

// ===== design/tns_ram.sv =====
// generic single-clock ram, one write and one registered read port
module tns_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tns_coord_lane.sv =====
// one coordinate axis: interpolate, clamp to [0,1], scale and clamp to a pixel
module tns_coord_lane import tns_pkg::*; (
  input  logic                     clk_i,
  input  logic signed [CoordW-1:0] a_i,
  input  logic signed [CoordW-1:0] b_i,
  input  logic signed [CoordW-1:0] c_i,
  input  logic [WeightW-1:0]       wu_i,
  input  logic [WeightW-1:0]       wv_i,
  input  logic [SizeW-1:0]         size_i,
  output logic [PixW-1:0]          pix_o
);

  localparam int DiffW = CoordW + 1;
  localparam int ProdW = DiffW + WeightW + 1;
  localparam int BaseW = CoordW + 15;
  localparam int AccW  = ProdW + 2;
  localparam int TW    = 31;
  localparam int ScW   = TW + SizeW;
  localparam logic signed [AccW-1:0] OneAcc = AccW'(64'sd1 <<< 30);

  logic signed [CoordW-1:0] a_q;
  logic signed [DiffW-1:0]  db_q, dc_q;
  logic [WeightW-1:0]       wu_q, wv_q;
  logic signed [BaseW-1:0]  base_q;
  logic signed [ProdW-1:0]  pb_q, pc_q;
  logic signed [AccW-1:0]   acc;
  logic [TW-1:0]            t_d, t_q;
  logic [ScW-1:0]           scaled;
  logic [PixW-1:0]          p_q;
  logic [SizeW-1:0]         last_pix;
  logic [PixW-1:0]          pix_d, pix_q;

  always_ff @(posedge clk_i) begin
    a_q    <= a_i;
    db_q   <= DiffW'(b_i) - DiffW'(a_i);
    dc_q   <= DiffW'(c_i) - DiffW'(a_i);
    wu_q   <= wu_i;
    wv_q   <= wv_i;
    base_q <= BaseW'(a_q) <<< 15;
    pb_q   <= ProdW'(db_q) * ProdW'(signed'({1'b0, wu_q}));
    pc_q   <= ProdW'(dc_q) * ProdW'(signed'({1'b0, wv_q}));
    t_q    <= t_d;
    p_q    <= scaled[ScW-2 -: PixW];
    pix_q  <= pix_d;
  end

  always_comb begin
    acc = AccW'(base_q) + AccW'(pb_q) + AccW'(pc_q);
    if (acc < 0) begin
      t_d = '0;
    end else if (acc > OneAcc) begin
      t_d = TW'(OneAcc);
    end else begin
      t_d = acc[TW-1:0];
    end
  end

  assign scaled   = ScW'(t_q) * ScW'(size_i);
  assign last_pix = size_i - SizeW'(1);

  always_comb begin
    if (size_i == '0) begin
      pix_d = '0;
    end else if (p_q > PixW'(last_pix)) begin
      // a coordinate of exactly one lands here
      pix_d = PixW'(last_pix);
    end else begin
      pix_d = p_q;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== design/tns_modulate.sv =====
// per-channel diffuse modulation, (d*p+127)/255, two register stages
module tns_modulate import tns_pkg::*; (
  input  logic clk_i,
  input  rgb_t diffuse_i,
  input  rgb_t texel_i,
  output rgb_t color_o
);

  logic [2*ColorW-1:0] v_q [3];
  logic [ColorW-1:0]   c_q [3];
  logic [ColorW-1:0]   d_ch [3];
  logic [ColorW-1:0]   p_ch [3];

  assign d_ch[0] = diffuse_i.red;
  assign d_ch[1] = diffuse_i.green;
  assign d_ch[2] = diffuse_i.blue;
  assign p_ch[0] = texel_i.red;
  assign p_ch[1] = texel_i.green;
  assign p_ch[2] = texel_i.blue;

  for (genvar k = 0; k < 3; k++) begin : g_ch
    always_ff @(posedge clk_i) begin
      v_q[k] <= (2*ColorW)'(d_ch[k]) * (2*ColorW)'(p_ch[k]) + (2*ColorW)'(127);
      c_q[k] <= div255(v_q[k]);
    end
  end

  assign color_o.red   = c_q[0];
  assign color_o.green = c_q[1];
  assign color_o.blue  = c_q[2];

endmodule

// ===== design/tns_out_fifo.sv =====
// result queue between the sampling pipeline and the output stream
module tns_out_fifo import tns_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  localparam int PtrW = $clog2(OutFifoDepth);
  localparam int CntW = $clog2(OutFifoDepth + 1);

  result_t         mem_q [OutFifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop);
    end
  end

endmodule

// ===== design/texture_nearest_sample_core.sv =====
// Nearest-neighbor texture sampler. Takes one request per clock: corner writes go straight
// into three corner banks (one per triangle corner, MAX_FACES deep), texel writes and texel
// reads share the texture memory at a fixed pipeline stage, so requests are served strictly
// in order. Each accepted sample leaves its result in a 16-entry output queue; s_axis_tready
// drops only when the samples in flight plus those queued would fill that queue, so with
// the output stream taking one result per clock the sustained rate is one request per
// cycle. Configuration writes take effect at once and must only be made while no sample
// is in flight. No clearing pass runs after reset.
module texture_nearest_sample_core import tns_pkg::*; #(
  parameter int MAX_FACES = MaxFacesDef,
  parameter int TEX_WORDS = TexWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // func, face, corner, tex_u, tex_v, texel_address, texel_red, texel_green, texel_blue,
  // bary_u, bary_v
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  // out_red, out_green, out_blue, pixel_x, pixel_y, zero fill
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  // address_error
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

`include "texture_nearest_sample_core_defines.svh"

  localparam int FaceAw = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int TexAw  = (TEX_WORDS > 1) ? $clog2(TEX_WORDS) : 1;
  localparam int CntW   = $clog2(OutFifoDepth + 1);
  localparam int TailN  = 3;

  typedef struct packed {
    logic                  smp;
    logic                  twr;
    logic [TexAddrInW-1:0] taddr;
    rgb_t                  texel;
  } ctl_t;

  typedef struct packed {
    ctl_t            ctl;
    logic [PixW-1:0] x;
    logic [PixW-1:0] y;
    logic [AddrW-1:0] prod;
  } addr_stage_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [PixOutW-1:0] x;
    logic [PixOutW-1:0] y;
    logic [AddrW-1:0]   addr;
    logic               err;
  } mem_stage_t;

  typedef struct packed {
    logic               smp;
    logic               err;
    logic [PixOutW-1:0] x;
    logic [PixOutW-1:0] y;
  } tail_t;

  // configuration
  rgb_t             diffuse_q;
  logic [SizeW-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diffuse_q <= '{red: 8'd255, green: 8'd255, blue: 8'd255};
      width_q   <= SizeW'(256);
      height_q  <= SizeW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIFFUSE_RED:   diffuse_q.red   <= cfg_data_i[ColorW-1:0];
        CFG_DIFFUSE_GREEN: diffuse_q.green <= cfg_data_i[ColorW-1:0];
        CFG_DIFFUSE_BLUE:  diffuse_q.blue  <= cfg_data_i[ColorW-1:0];
        CFG_IMAGE_WIDTH:   width_q         <= cfg_data_i[SizeW-1:0];
        CFG_IMAGE_HEIGHT:  height_q        <= cfg_data_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [FuncW-1:0]      in_func;
  logic [FaceW-1:0]      in_face;
  logic [CornerSelW-1:0] in_corner;
  logic [CoordW-1:0]     in_tex_u, in_tex_v;
  logic [TexAddrInW-1:0] in_taddr;
  rgb_t                  in_texel;
  logic [WeightW-1:0]    in_bary_u, in_bary_v;

  assign in_func        = s_axis_tdata[1:0];
  assign in_face        = s_axis_tdata[11:2];
  assign in_corner      = s_axis_tdata[13:12];
  assign in_tex_u       = s_axis_tdata[30:14];
  assign in_tex_v       = s_axis_tdata[47:31];
  assign in_taddr       = s_axis_tdata[63:48];
  assign in_texel.red   = s_axis_tdata[71:64];
  assign in_texel.green = s_axis_tdata[79:72];
  assign in_texel.blue  = s_axis_tdata[87:80];
  assign in_bary_u      = s_axis_tdata[103:88];
  assign in_bary_v      = s_axis_tdata[119:104];

  logic            accept, face_ok, texel_ok, sample_acc, m_pop;
  logic [CntW-1:0] cnt_q;

  assign s_axis_tready = (cnt_q < CntW'(OutFifoDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign face_ok       = (32'(in_face) < 32'(MAX_FACES));
  assign texel_ok      = (32'(in_taddr) < 32'(TEX_WORDS));
  assign sample_acc    = accept && (in_func == FUNC_SAMPLE);
  assign m_pop         = m_axis_tvalid && m_axis_tready;

  // credits: samples accepted and not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CntW'(sample_acc) - CntW'(m_pop);
    end
  end

  // corner banks, one per triangle corner
  logic [CornerW-1:0] corner_rd [3];
  logic [CornerW-1:0] corner_wd;
  logic               face_ok_q;
  logic [WeightW-1:0] wu_q, wv_q;

  assign corner_wd = {in_tex_v, in_tex_u};

  for (genvar k = 0; k < 3; k++) begin : g_bank
    tns_ram #(
      .Width(CornerW),
      .Depth(MAX_FACES)
    ) u_corner_ram (
      .clk_i   (clk_i),
      .we_i    (accept && (in_func == FUNC_WR_CORNER) && face_ok &&
                (in_corner == CornerSelW'(k))),
      .waddr_i (FaceAw'(in_face)),
      .wdata_i (corner_wd),
      .re_i    (sample_acc && face_ok),
      .raddr_i (FaceAw'(in_face)),
      .rdata_o (corner_rd[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (sample_acc) begin
      face_ok_q <= face_ok;
      wu_q      <= in_bary_u;
      wv_q      <= in_bary_v;
    end
  end

  // control shift line alongside the coordinate lanes
  ctl_t ctl_d;
  ctl_t ctl_q [LaneLat+1];

  assign ctl_d.smp   = sample_acc;
  assign ctl_d.twr   = accept && (in_func == FUNC_WR_TEXEL) && texel_ok;
  assign ctl_d.taddr = in_taddr;
  assign ctl_d.texel = in_texel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LaneLat; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i <= LaneLat; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // a face beyond the table reads as all-zero corners
  logic [CornerW-1:0] e [3];
  for (genvar k = 0; k < 3; k++) begin : g_mask
    assign e[k] = face_ok_q ? corner_rd[k] : '0;
  end

  logic [PixW-1:0] pix_x, pix_y;

  tns_coord_lane u_lane_u (
    .clk_i  (clk_i),
    .a_i    (signed'(e[0][CoordW-1:0])),
    .b_i    (signed'(e[1][CoordW-1:0])),
    .c_i    (signed'(e[2][CoordW-1:0])),
    .wu_i   (wu_q),
    .wv_i   (wv_q),
    .size_i (width_q),
    .pix_o  (pix_x)
  );

  tns_coord_lane u_lane_v (
    .clk_i  (clk_i),
    .a_i    (signed'(e[0][CornerW-1:CoordW])),
    .b_i    (signed'(e[1][CornerW-1:CoordW])),
    .c_i    (signed'(e[2][CornerW-1:CoordW])),
    .wu_i   (wu_q),
    .wv_i   (wv_q),
    .size_i (height_q),
    .pix_o  (pix_y)
  );

  // texel address: row product, then add column and range check
  addr_stage_t as_q;
  mem_stage_t  ms_q;
  logic [AddrW-1:0] addr_d;

  assign addr_d = as_q.prod + AddrW'(as_q.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      as_q <= '0;
      ms_q <= '0;
    end else begin
      as_q.ctl  <= ctl_q[LaneLat];
      as_q.x    <= pix_x;
      as_q.y    <= pix_y;
      as_q.prod <= AddrW'(pix_y) * AddrW'(width_q);
      ms_q.ctl  <= as_q.ctl;
      ms_q.x    <= as_q.x[PixOutW-1:0];
      ms_q.y    <= as_q.y[PixOutW-1:0];
      ms_q.addr <= addr_d;
      ms_q.err  <= (32'(addr_d) >= 32'(TEX_WORDS));
    end
  end

  // texture memory: writes and reads meet at the same stage so order holds
  logic tex_we, tex_re;
  rgb_t tex_rd;

  assign tex_we = ms_q.ctl.twr;
  assign tex_re = ms_q.ctl.smp && !ms_q.err;

  tns_ram #(
    .Width(TexelW),
    .Depth(TEX_WORDS)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .we_i    (tex_we),
    .waddr_i (TexAw'(ms_q.ctl.taddr)),
    .wdata_i (ms_q.ctl.texel),
    .re_i    (tex_re),
    .raddr_i (TexAw'(ms_q.addr)),
    .rdata_o (tex_rd)
  );

  tail_t tail_q [TailN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TailN; i++) begin
        tail_q[i] <= '0;
      end
    end else begin
      tail_q[0] <= '{smp: ms_q.ctl.smp, err: ms_q.err, x: ms_q.x, y: ms_q.y};
      for (int i = 1; i < TailN; i++) begin
        tail_q[i] <= tail_q[i-1];
      end
    end
  end

  rgb_t mod_color;

  tns_modulate u_modulate (
    .clk_i     (clk_i),
    .diffuse_i (diffuse_q),
    .texel_i   (tex_rd),
    .color_o   (mod_color)
  );

  result_t push_data, out_data;

  assign push_data.err     = tail_q[TailN-1].err;
  assign push_data.pixel_x = tail_q[TailN-1].x;
  assign push_data.pixel_y = tail_q[TailN-1].y;
  assign push_data.color   = tail_q[TailN-1].err ? '0 : mod_color;

  tns_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tail_q[TailN-1].smp),
    .push_data_i (push_data),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (out_data)
  );

  assign m_axis_tdata = {4'b0, out_data.pixel_y, out_data.pixel_x, out_data.color.blue,
                         out_data.color.green, out_data.color.red};
  assign m_axis_tuser = out_data.err;

  `TNS_ASSERT(a_tex_port_excl, clk_i, rst_ni, !(tex_we && tex_re))
  `TNS_ASSERT(a_credit_bound, clk_i, rst_ni, cnt_q <= CntW'(OutFifoDepth))
  `TNS_ASSERT(a_err_black, clk_i, rst_ni, !(m_axis_tvalid && m_axis_tuser) || (m_axis_tdata[23:0] == 24'd0))
  `TNS_ASSERT_NEXT(a_full_stall, clk_i, rst_ni, (sample_acc && !m_pop && (cnt_q == CntW'(OutFifoDepth - 1))), !s_axis_tready)

endmodule
